// ===== hdl/bvre_pkg.sv =====
package bvre_pkg;

   typedef struct packed {
      logic [2:0]  command;
      logic [9:0]  position;
      logic [10:0] run_length;
      logic        fill_value;
      logic [7:0]  write_data;
   } bvre_req_type;

   typedef struct packed {
      logic        bit_out;
      logic [7:0]  byte_out;
      logic [10:0] current_length;
      logic [1:0]  status;
   } bvre_rsp_type;

   localparam logic [2:0] CMD_READ_BIT   = 3'd0;
   localparam logic [2:0] CMD_READ_BYTE  = 3'd1;
   localparam logic [2:0] CMD_WRITE_BYTE = 3'd2;
   localparam logic [2:0] CMD_FILL_RUN   = 3'd3;
   localparam logic [2:0] CMD_INSERT_RUN = 3'd4;
   localparam logic [2:0] CMD_REMOVE_RUN = 3'd5;
   localparam logic [2:0] CMD_APPEND_RUN = 3'd6;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_RANGE    = 2'd1;
   localparam logic [1:0] ST_CAPACITY = 2'd2;

   // operation broadcast to every cell of the chain
   typedef enum logic [2:0] {
      OP_HOLD,
      OP_SHR,
      OP_SHL,
      OP_FILL,
      OP_READ
   } bvre_op_type;

   typedef struct packed {
      bvre_op_type op;
      logic        fill_value;
      logic        use_data;
      logic [7:0]  write_data;
   } bvre_ctrl_type;

endpackage

// ===== hdl/bit_vector_range_engine_core.sv =====
// channel   ports                           direction
// request   req_valid / req_ready / req_payload   in
// response  rsp_valid / rsp_ready / rsp_payload   out
//
// one transaction at a time; bits live in a chain of word cells
// read bit / read byte: a pass of the read or-chain through every cell (S_READ)
// insert / remove: S_SHIFT, one bit shift of the tail per cycle
// other commands: S_EXEC then S_RESP; every command waits in S_RESP while rsp_ready stays low
// synchronous reset clears the store and the length
module bit_vector_range_engine_core import bvre_pkg::*; #(
   parameter int CAPACITY_BITS = 1024,
   parameter int WORD_BITS     = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  bvre_req_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output bvre_rsp_type rsp_payload
);

   localparam int NCELL = (CAPACITY_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int LEN_W = $clog2(CAPACITY_BITS + 1);
   localparam int SUM_W = ((LEN_W > 11) ? LEN_W : 11) + 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SHIFT,
      S_READ,
      S_RESP
   } state_type;

   state_type        state_ff, state_in;
   bvre_req_type     req_ff, req_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [SUM_W-1:0] cnt_ff, cnt_in;
   logic             bit_ff, bit_in;
   logic [7:0]       byte_ff, byte_in;
   logic [1:0]       status_ff, status_in;

   bvre_ctrl_type    ctrl;
   logic [SUM_W-1:0] lo, hi;
   logic [SUM_W-1:0] pos_x, run_x, len_x, cap_x;

   logic [WORD_BITS-1:0] words [NCELL];
   logic [7:0]           rds [NCELL];

   assign pos_x = SUM_W'(req_ff.position);
   assign run_x = SUM_W'(req_ff.run_length);
   assign len_x = SUM_W'(len_ff);
   assign cap_x = SUM_W'(CAPACITY_BITS);

   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      len_in    = len_ff;
      cnt_in    = cnt_ff;
      bit_in    = bit_ff;
      byte_in   = byte_ff;
      status_in = status_ff;
      ctrl.op         = OP_HOLD;
      ctrl.fill_value = req_ff.fill_value;
      ctrl.use_data   = 1'b0;
      ctrl.write_data = req_ff.write_data;
      lo = pos_x;
      hi = pos_x + run_x;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_payload;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            status_in = ST_OK;
            bit_in    = 1'b0;
            byte_in   = '0;
            state_in  = S_RESP;
            unique case (req_ff.command)
               CMD_READ_BIT: begin
                  if (pos_x < len_x) begin
                     cnt_in   = SUM_W'(NCELL);
                     state_in = S_READ;
                  end else begin
                     status_in = ST_RANGE;
                  end
               end
               CMD_READ_BYTE: begin
                  if (pos_x + SUM_W'(8) <= len_x) begin
                     cnt_in   = SUM_W'(NCELL);
                     state_in = S_READ;
                  end else begin
                     status_in = ST_RANGE;
                  end
               end
               CMD_WRITE_BYTE: begin
                  if (pos_x + SUM_W'(8) <= len_x) begin
                     ctrl.op       = OP_FILL;
                     ctrl.use_data = 1'b1;
                     hi            = pos_x + SUM_W'(8);
                  end else begin
                     status_in = ST_RANGE;
                  end
               end
               CMD_FILL_RUN: begin
                  if (pos_x + run_x <= len_x) begin
                     ctrl.op = OP_FILL;
                  end else begin
                     status_in = ST_RANGE;
                  end
               end
               CMD_INSERT_RUN: begin
                  if (pos_x > len_x) begin
                     status_in = ST_RANGE;
                  end else if (len_x + run_x > cap_x) begin
                     status_in = ST_CAPACITY;
                  end else begin
                     len_in = LEN_W'(len_x + run_x);
                     cnt_in = run_x;
                     if (run_x != '0) begin
                        state_in = S_SHIFT;
                     end
                  end
               end
               CMD_REMOVE_RUN: begin
                  if (pos_x + run_x <= len_x) begin
                     len_in = LEN_W'(len_x - run_x);
                     cnt_in = run_x;
                     if (run_x != '0) begin
                        state_in = S_SHIFT;
                     end
                  end else begin
                     status_in = ST_RANGE;
                  end
               end
               CMD_APPEND_RUN: begin
                  if (len_x + run_x > cap_x) begin
                     status_in = ST_CAPACITY;
                  end else begin
                     ctrl.op = OP_FILL;
                     lo      = len_x;
                     hi      = len_x + run_x;
                     len_in  = LEN_W'(len_x + run_x);
                  end
               end
               default: ;
            endcase
         end
         S_SHIFT: begin
            ctrl.op = (req_ff.command == CMD_INSERT_RUN) ? OP_SHR : OP_SHL;
            cnt_in  = cnt_ff - SUM_W'(1);
            if (cnt_ff == SUM_W'(1)) begin
               state_in = S_RESP;
            end
         end
         S_READ: begin
            if (cnt_ff != '0) begin
               ctrl.op = OP_READ;
               cnt_in  = cnt_ff - SUM_W'(1);
            end else begin
               if (req_ff.command == CMD_READ_BIT) begin
                  bit_in  = rds[NCELL-1][7];
                  byte_in = '0;
               end else begin
                  bit_in  = 1'b0;
                  byte_in = rds[NCELL-1];
               end
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         len_ff    <= '0;
         cnt_ff    <= '0;
         bit_ff    <= 1'b0;
         byte_ff   <= '0;
         status_ff <= ST_OK;
      end else begin
         state_ff  <= state_in;
         len_ff    <= len_in;
         cnt_ff    <= cnt_in;
         bit_ff    <= bit_in;
         byte_ff   <= byte_in;
         status_ff <= status_in;
      end
      req_ff <= req_in;
   end

   for (genvar c = 0; c < NCELL; c++) begin : g_cell
      logic       prev_last;
      logic       next_first;
      logic [7:0] rd_prev;

      if (c == 0) begin : g_first
         assign prev_last = 1'b0;
         assign rd_prev   = '0;
      end else begin : g_mid
         assign prev_last = words[c-1][WORD_BITS-1];
         assign rd_prev   = rds[c-1];
      end

      // tail end of the chain feeds zeros into a left shift
      if (c == NCELL - 1) begin : g_last
         assign next_first = 1'b0;
      end else begin : g_next
         assign next_first = words[c+1][0];
      end

      bvre_cell #(
         .WORD_BITS (WORD_BITS),
         .IDX_W     (SUM_W),
         .BASE      (c * WORD_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .lo         (lo),
         .hi         (hi),
         .prev_last  (prev_last),
         .next_first (next_first),
         .rd_prev    (rd_prev),
         .word       (words[c]),
         .rd         (rds[c])
      );
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   assign rsp_payload.bit_out        = bit_ff;
   assign rsp_payload.byte_out       = byte_ff;
   assign rsp_payload.current_length = 11'(len_ff);
   assign rsp_payload.status         = status_ff;

endmodule

// ===== hdl/bvre_cell.sv =====
module bvre_cell import bvre_pkg::*; #(
   parameter int WORD_BITS = 8,
   parameter int IDX_W     = 12,
   parameter int BASE      = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  bvre_ctrl_type        ctrl,
   input  logic [IDX_W-1:0]     lo,
   input  logic [IDX_W-1:0]     hi,
   input  logic                 prev_last,
   input  logic                 next_first,
   input  logic [7:0]           rd_prev,
   output logic [WORD_BITS-1:0] word,
   output logic [7:0]           rd
);

   // bit k of word_ff is vector bit BASE + k
   logic [WORD_BITS-1:0] word_ff, word_in;
   logic [7:0]           rd_ff, rd_in;
   logic [WORD_BITS-1:0] shr_src, shl_src;

   assign shr_src = {word_ff[WORD_BITS-2:0], prev_last};
   assign shl_src = {next_first, word_ff[WORD_BITS-1:1]};

   always_comb begin
      logic [IDX_W-1:0] idx;
      logic [IDX_W-1:0] rel_pos;
      logic             ge;
      logic [7:0]       contrib;
      word_in = word_ff;
      contrib = '0;
      for (int k = 0; k < WORD_BITS; k++) begin
         idx     = IDX_W'(BASE + k);
         rel_pos = idx - lo;
         ge      = (idx >= lo);
         case (ctrl.op)
            OP_SHR: begin
               if (ge) begin
                  word_in[k] = (idx == lo) ? ctrl.fill_value : shr_src[k];
               end
            end
            OP_SHL: begin
               if (ge) begin
                  word_in[k] = shl_src[k];
               end
            end
            OP_FILL: begin
               if (ge && (idx < hi)) begin
                  word_in[k] = ctrl.use_data ? ctrl.write_data[3'd7 - rel_pos[2:0]]
                                             : ctrl.fill_value;
               end
            end
            OP_READ: begin
               if (ge && (rel_pos < IDX_W'(8))) begin
                  contrib[3'd7 - rel_pos[2:0]] = word_ff[k];
               end
            end
            default: ;
         endcase
      end
      // read window is or-ed along the chain, one cell per cycle
      rd_in = (ctrl.op == OP_READ) ? (contrib | rd_prev) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff <= '0;
         rd_ff   <= '0;
      end else begin
         word_ff <= word_in;
         rd_ff   <= rd_in;
      end
   end

   assign word = word_ff;
   assign rd   = rd_ff;

endmodule
